[hw/rtl/sparse_set_component_store_assert.svh]
// Assertion macros used by the sparse-set component store checker.
// Depends on nothing; each macro expects signals named clk and rst in scope.
`ifndef SPARSE_SET_COMPONENT_STORE_ASSERT_SVH
`define SPARSE_SET_COMPONENT_STORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sscs_pkg.sv]
// Package for the sparse-set component store: request and result types,
// request and status codes, and default sizes. Depends on nothing.
package sscs_pkg;

  localparam int DEF_CAPACITY     = 256;
  localparam int DEF_ENTITY_SPACE = 1024;
  localparam int DEF_PAYLOAD_BITS = 64;

  localparam int ENT_W   = 10;
  localparam int SLOT_W  = 8;
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 9;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_PRESENT   = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ENT_W-1:0]  entity_id;
    logic [SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0] component_data;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               present;
    logic [SLOT_W-1:0]  found_slot;
    logic [ENT_W-1:0]   found_entity;
    logic [DATA_W-1:0]  payload_out;
    logic [COUNT_W-1:0] live_count;
  } rsp_t;

endpackage

[hw/rtl/sscs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sscs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/sparse_set_component_store.sv]
// Top level of the sparse-set component store with swap-remove.
// Depends on sscs_pkg and sscs_ram.
//
// Usage: a transaction is taken at a rising edge where start is high and
// busy is low; req carries the request type, entity, slot and payload.
// Each transaction gives exactly one result on rsp, marked by done for one
// cycle. The receiver cannot hold results off, so rsp is valid only then.
// Steps after the accepting edge: a read by slot finishes in S_SPARSE;
// insert, lookup and a remove that misses go on to S_DENSE; a remove
// that hits goes on from S_DENSE to S_MOVE. done is registered from the last state.
// A new transaction is taken in the same cycle that done is high, but not
// before: busy stays high while one is in flight. The states are set by
// the dependent reads: the sparse table gives the slot, then the dense
// memory is read at that slot, and remove reads the last dense entry
// before writing it back into the freed slot. Each memory has one
// registered read port.
// After reset the sparse table is cleared one entry a cycle, which keeps
// busy high until every entry is cleared; the live count starts at zero.
module sparse_set_component_store #(
  parameter int CAPACITY     = sscs_pkg::DEF_CAPACITY,
  parameter int ENTITY_SPACE = sscs_pkg::DEF_ENTITY_SPACE,
  parameter int PAYLOAD_BITS = sscs_pkg::DEF_PAYLOAD_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sscs_pkg::req_t req,
  output logic           done,
  output sscs_pkg::rsp_t rsp
);

  import sscs_pkg::*;

  localparam int SLOT_AW = $clog2(CAPACITY);
  localparam int ENT_AW  = $clog2(ENTITY_SPACE);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int DN_W    = ENT_W + PAYLOAD_BITS;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SPARSE = 2'd1;
  localparam logic [1:0] S_DENSE  = 2'd2;
  localparam logic [1:0] S_MOVE   = 2'd3;

  logic [1:0]              state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic                    clearing;
  logic [ENT_AW-1:0]       clr_addr;
  logic [1:0]              r_type;
  logic [ENT_W-1:0]        r_ent;
  logic                    r_ent_ok;
  logic [SLOT_W-1:0]       r_sidx;
  logic [PAYLOAD_BITS-1:0] r_data;
  logic [SLOT_AW-1:0]      r_slot, r_slot_next;
  logic [PAYLOAD_BITS-1:0] r_pay, r_pay_next;
  logic                    done_next;
  rsp_t                    rsp_next;

  logic                    sp_we;
  logic [ENT_AW-1:0]       sp_waddr, sp_raddr;
  logic [SLOT_AW-1:0]      sp_wdata, sp_rdata;
  logic                    dn_we;
  logic [SLOT_AW-1:0]      dn_waddr, dn_raddr;
  logic [DN_W-1:0]         dn_wdata, dn_rdata;

  logic                    accept;
  logic [ENT_W-1:0]        dn_ent;
  logic [PAYLOAD_BITS-1:0] dn_pay;
  logic                    hit;
  logic [SLOT_AW-1:0]      last;

  sscs_ram #(.WIDTH(SLOT_AW), .DEPTH(ENTITY_SPACE)) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  sscs_ram #(.WIDTH(DN_W), .DEPTH(CAPACITY)) u_dense (
    .clk   (clk),
    .we    (dn_we),
    .waddr (dn_waddr),
    .wdata (dn_wdata),
    .raddr (dn_raddr),
    .rdata (dn_rdata)
  );

  assign busy   = clearing || (state != S_IDLE);
  assign accept = start && !busy;
  assign dn_ent = dn_rdata[DN_W-1:PAYLOAD_BITS];
  assign dn_pay = dn_rdata[PAYLOAD_BITS-1:0];
  assign last   = SLOT_AW'(count - CNT_W'(1));
  assign hit    = r_ent_ok && (CNT_W'(r_slot) < count) && (dn_ent == r_ent);
  assign sp_raddr = ENT_AW'(req.entity_id);

  always_comb begin
    state_next  = state;
    count_next  = count;
    r_slot_next = r_slot;
    r_pay_next  = r_pay;
    done_next   = 1'b0;
    rsp_next    = '0;
    rsp_next.status     = STAT_NOT_FOUND;
    rsp_next.live_count = COUNT_W'(count);
    sp_we    = 1'b0;
    sp_waddr = clr_addr;
    sp_wdata = '0;
    dn_we    = 1'b0;
    dn_waddr = SLOT_AW'(count);
    dn_wdata = {r_ent, r_data};
    dn_raddr = SLOT_AW'(req.slot_index);

    if (clearing) begin
      sp_we = 1'b1;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SPARSE;
        end
      end
      S_SPARSE: begin
        r_slot_next = sp_rdata;
        dn_raddr    = sp_rdata;
        if (r_type == REQ_READ) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (32'(r_sidx) < 32'(count)) begin
            rsp_next.status       = STAT_OK;
            rsp_next.present      = 1'b1;
            rsp_next.found_slot   = r_sidx;
            rsp_next.found_entity = dn_ent;
            rsp_next.payload_out  = DATA_W'(dn_pay);
          end
        end else begin
          state_next = S_DENSE;
        end
      end
      S_DENSE: begin
        dn_raddr   = last;
        state_next = S_IDLE;
        done_next  = 1'b1;
        case (r_type)
          REQ_INSERT: begin
            if (!r_ent_ok) begin
              rsp_next.status = STAT_NOT_FOUND;
            end else if (hit) begin
              rsp_next.status      = STAT_PRESENT;
              rsp_next.present     = 1'b1;
              rsp_next.found_slot  = SLOT_W'(r_slot);
              rsp_next.payload_out = DATA_W'(dn_pay);
            end else if (count == CNT_W'(CAPACITY)) begin
              rsp_next.status = STAT_FULL;
            end else begin
              dn_we      = 1'b1;
              sp_we      = 1'b1;
              sp_waddr   = ENT_AW'(r_ent);
              sp_wdata   = SLOT_AW'(count);
              count_next = count + CNT_W'(1);
              rsp_next.status      = STAT_OK;
              rsp_next.present     = 1'b1;
              rsp_next.found_slot  = SLOT_W'(count);
              rsp_next.payload_out = DATA_W'(r_data);
              rsp_next.live_count  = COUNT_W'(count + CNT_W'(1));
            end
          end
          REQ_REMOVE: begin
            if (hit) begin
              r_pay_next = dn_pay;
              done_next  = 1'b0;
              state_next = S_MOVE;
            end
          end
          REQ_LOOKUP: begin
            if (hit) begin
              rsp_next.status      = STAT_OK;
              rsp_next.present     = 1'b1;
              rsp_next.found_slot  = SLOT_W'(r_slot);
              rsp_next.payload_out = DATA_W'(dn_pay);
            end
          end
          default: begin
            rsp_next.status = STAT_NOT_FOUND;
          end
        endcase
      end
      S_MOVE: begin
        dn_we      = 1'b1;
        dn_waddr   = r_slot;
        dn_wdata   = dn_rdata;
        sp_we      = 1'b1;
        sp_waddr   = ENT_AW'(dn_ent);
        sp_wdata   = r_slot;
        count_next = count - CNT_W'(1);
        state_next = S_IDLE;
        done_next  = 1'b1;
        rsp_next.status      = STAT_OK;
        rsp_next.found_slot  = SLOT_W'(r_slot);
        rsp_next.payload_out = DATA_W'(r_pay);
        rsp_next.live_count  = COUNT_W'(count - CNT_W'(1));
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (clearing) begin
        clr_addr <= clr_addr + ENT_AW'(1);
        if (clr_addr == ENT_AW'(ENTITY_SPACE - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    r_slot <= r_slot_next;
    r_pay  <= r_pay_next;
    rsp    <= rsp_next;
    if (accept) begin
      r_type   <= req.req_type;
      r_ent    <= req.entity_id;
      r_ent_ok <= 32'(req.entity_id) < 32'(ENTITY_SPACE);
      r_sidx   <= req.slot_index;
      r_data   <= PAYLOAD_BITS'(req.component_data);
    end
  end

endmodule

[hw/rtl/sscs_checker.sv]
// Port-level checker for the sparse-set component store and its bind.
// Depends on sscs_pkg and sparse_set_component_store_assert.svh.
`include "sparse_set_component_store_assert.svh"

module sscs_checker #(
  parameter int CAPACITY = sscs_pkg::DEF_CAPACITY
) (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input sscs_pkg::rsp_t rsp
);

  import sscs_pkg::*;

  `SSCS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy low after a transaction")
  `SSCS_ASSERT_NOW(a_done_needs_work, done, $past(busy), "result without a transaction")
  `SSCS_ASSERT_NEXT(a_done_single, done, !done, "two results in consecutive cycles")
  `SSCS_ASSERT_NOW(a_count_bound, done, 32'(rsp.live_count) <= 32'(CAPACITY), "count too large")
  `SSCS_ASSERT_NOW(a_full_not_present, done && rsp.status == STAT_FULL, !rsp.present,
    "full result marked present")

endmodule

bind sparse_set_component_store sscs_checker #(.CAPACITY(CAPACITY)) u_sscs_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

[test/sparse_set_component_store_test.sv]
// Self-checking testbench for the sparse-set component store with swap-remove.
// Depends on sscs_pkg and sparse_set_component_store; a scoreboard class predicts each
// result from its own copy of the packed and sparse stores and checks it field by field.
module sparse_set_component_store_test;
  import sscs_pkg::*;

  localparam int CAP  = DEF_CAPACITY;
  localparam int ENTS = DEF_ENTITY_SPACE;

  class store_scoreboard;
    logic [DATA_W-1:0] payload_mem [CAP];
    logic [ENT_W-1:0]  slot_owner [CAP];
    int unsigned       slot_of [ENTS];
    int unsigned       live;
    int unsigned       peak;
    rsp_t              pending [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       status_seen [4];

    function new();
      foreach (payload_mem[i]) payload_mem[i] = '0;
      foreach (slot_owner[i]) slot_owner[i] = '0;
      foreach (slot_of[i]) slot_of[i] = 0;
      live = 0;
      peak = 0;
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function bit find_entity(input logic [ENT_W-1:0] ent, output int unsigned s);
      s = slot_of[ent];
      return (s < live) && (slot_owner[s] == ent);
    endfunction

    function rsp_t apply_request(req_t r);
      rsp_t o;
      int unsigned s;
      int unsigned last;
      logic [ENT_W-1:0] moved;
      o = '0;
      o.status = STAT_NOT_FOUND;
      case (r.req_type)
        REQ_INSERT: begin
          if (find_entity(r.entity_id, s)) begin
            o.status = STAT_PRESENT;
            o.present = 1'b1;
            o.found_slot = s[SLOT_W-1:0];
            o.payload_out = payload_mem[s];
          end else if (live >= CAP) begin
            o.status = STAT_FULL;
          end else begin
            s = live;
            payload_mem[s] = r.component_data;
            slot_owner[s] = r.entity_id;
            slot_of[r.entity_id] = s;
            live++;
            o.status = STAT_OK;
            o.present = 1'b1;
            o.found_slot = s[SLOT_W-1:0];
            o.payload_out = r.component_data;
          end
        end
        REQ_REMOVE: begin
          if (find_entity(r.entity_id, s)) begin
            last = live - 1;
            moved = slot_owner[last];
            o.payload_out = payload_mem[s];
            payload_mem[s] = payload_mem[last];
            slot_owner[s] = moved;
            slot_of[moved] = s;
            live = last;
            o.status = STAT_OK;
            o.found_slot = s[SLOT_W-1:0];
          end
        end
        REQ_LOOKUP: begin
          if (find_entity(r.entity_id, s)) begin
            o.status = STAT_OK;
            o.present = 1'b1;
            o.found_slot = s[SLOT_W-1:0];
            o.payload_out = payload_mem[s];
          end
        end
        default: begin
          if (r.slot_index < live) begin
            o.status = STAT_OK;
            o.present = 1'b1;
            o.found_slot = r.slot_index;
            o.found_entity = slot_owner[r.slot_index];
            o.payload_out = payload_mem[r.slot_index];
          end
        end
      endcase
      o.live_count = live[COUNT_W-1:0];
      if (live > peak) peak = live;
      return o;
    endfunction

    function void note_request(req_t r);
      pending.insert(pending.size(), apply_request(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with no transaction outstanding: %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.status !== want.status || got.present !== want.present ||
          got.found_slot !== want.found_slot || got.found_entity !== want.found_entity ||
          got.payload_out !== want.payload_out || got.live_count !== want.live_count) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d mismatch", checked);
          $display("  expected status %0d present %0d slot %0d entity %0d payload %h count %0d",
                   want.status, want.present, want.found_slot, want.found_entity,
                   want.payload_out, want.live_count);
          $display("  actual   status %0d present %0d slot %0d entity %0d payload %h count %0d",
                   got.status, got.present, got.found_slot, got.found_entity,
                   got.payload_out, got.live_count);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;
  int unsigned sent = 0;

  store_scoreboard sb = new();

  sparse_set_component_store i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(rsp);
  end

  initial begin
    #400000;
    $display("ERROR: timeout with %0d transactions outstanding", sb.pending.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic req_t make_req(logic [1:0] kind, logic [ENT_W-1:0] ent,
                                    logic [SLOT_W-1:0] slot, logic [DATA_W-1:0] data);
    req_t r;
    r.req_type = kind;
    r.entity_id = ent;
    r.slot_index = slot;
    r.component_data = data;
    return r;
  endfunction

  function automatic req_t pick_req(int unsigned ins_w, int unsigned rem_w,
                                    int unsigned look_w);
    int unsigned roll;
    logic [1:0] kind;
    logic [ENT_W-1:0] ent;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data;
    roll = $urandom_range(99);
    if (roll < ins_w) kind = REQ_INSERT;
    else if (roll < ins_w + rem_w) kind = REQ_REMOVE;
    else if (roll < ins_w + rem_w + look_w) kind = REQ_LOOKUP;
    else kind = REQ_READ;
    ent = ENT_W'($urandom_range(ENTS - 1));
    if (sb.live > 0 && $urandom_range(99) < (kind == REQ_INSERT ? 15 : 70))
      ent = sb.slot_owner[$urandom_range(sb.live - 1)];
    slot = SLOT_W'($urandom_range(255));
    if (sb.live > 0 && $urandom_range(99) < 70) slot = SLOT_W'($urandom_range(sb.live - 1));
    data = {$urandom, $urandom};
    case ($urandom_range(19))
      0: data = '0;
      1: data = '1;
      default: ;
    endcase
    return make_req(kind, ent, slot, data);
  endfunction

  task automatic send_request(req_t r, bit may_idle);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    sent++;
    if (may_idle && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(make_req(REQ_LOOKUP, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_REMOVE, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_READ, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_INSERT, 10'd0, 8'd255, '0), 1'b0);
    send_request(make_req(REQ_INSERT, 10'd1023, 8'd0, '1), 1'b0);
    send_request(make_req(REQ_INSERT, 10'd0, 8'd0, 64'h0123_4567_89ab_cdef), 1'b0);
    send_request(make_req(REQ_LOOKUP, 10'd1023, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_LOOKUP, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_READ, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_READ, 10'd0, 8'd1, '0), 1'b0);
    send_request(make_req(REQ_READ, 10'd0, 8'd255, '0), 1'b0);
    send_request(make_req(REQ_INSERT, 10'd512, 8'd0, 64'ha5a5_5a5a_f0f0_0f0f), 1'b0);
    send_request(make_req(REQ_REMOVE, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_LOOKUP, 10'd512, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_READ, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_REMOVE, 10'd512, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_LOOKUP, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_INSERT, 10'd0, 8'd0, 64'h8000_0000_0000_0001), 1'b0);
    send_request(make_req(REQ_LOOKUP, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_REMOVE, 10'd1023, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_REMOVE, 10'd0, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_LOOKUP, 10'd1023, 8'd0, '0), 1'b0);
    send_request(make_req(REQ_REMOVE, 10'd1023, 8'd0, '0), 1'b0);
    drain();

    for (int i = 0; i < 40; i++) begin
      send_request(pick_req(35, 20, 25), !(i >= 10 && i < 35));
    end
    drain();

    while (sb.live < CAP) begin
      send_request(pick_req(95, 0, 5), 1'b1);
    end
    for (int i = 0; i < 10; i++) begin
      send_request(pick_req(50, 0, 25), 1'b1);
    end
    drain();

    for (int i = 0; i < 50; i++) begin
      send_request(pick_req(10, 60, 15), 1'b1);
    end
    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results, peak live count %0d.",
             sent, sb.checked, sb.peak);
    $display("Status counts: ok %0d, not found %0d, full %0d, already present %0d.",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_NOT_FOUND],
             sb.status_seen[STAT_FULL], sb.status_seen[STAT_PRESENT]);
    if (sb.pending.size() != 0) begin
      $display("ERROR: %0d results never arrived", sb.pending.size());
      sb.errors += sb.pending.size();
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
